@@ src/homogeneous_transform_project_core_macros.svh @@
// Assertion macros shared by the core's RTL.
// Included by files that check properties; needs no other file.
`ifndef HOMOGENEOUS_TRANSFORM_PROJECT_CORE_MACROS_SVH
`define HOMOGENEOUS_TRANSFORM_PROJECT_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define HXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hxp_pkg.sv @@
// Shared types and constants of the homogeneous transform core.
// No dependencies.
package hxp_pkg;

    localparam int COORD_BITS = 32;
    localparam int COEF_BITS  = 16;
    localparam int XFRAC      = COORD_BITS / 2;
    localparam int CFRAC      = COEF_BITS - 4;
    localparam int LANE_W     = 16;
    localparam int CFG_W      = 4 * LANE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = COORD_BITS + COEF_BITS;
    localparam int SUM_W      = PROD_W + 2;
    localparam int QUO_W      = COORD_BITS + XFRAC;
    localparam int DIV_LAT    = QUO_W + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COL0 = 2'd0,
        CFG_COL1 = 2'd1,
        CFG_COL2 = 2'd2,
        CFG_COL3 = 2'd3
    } t_cfg_reg;

    localparam t_coord ONE_COORD = t_coord'(1) << XFRAC;

    // Item travelling beside the divider lanes.
    typedef struct packed {
        logic   valid;
        logic   div;
        logic   sat;
        t_coord tx;
        t_coord ty;
        t_coord tz;
        t_coord tw;
    } t_ctl;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_coord w;
        logic   div;
        logic   sat;
    } t_res;

endpackage

@@ src/homogeneous_transform_project_core.sv @@
// Homogeneous point transform with optional perspective divide.
// Usage:
//   Input channel (i_valid / o_stall): one point and a command per transfer.
//   Output channel (o_valid / i_stall): one result per accepted point, in order.
//   Config channel (i_cfg_valid / o_cfg_ready): writes one matrix column; ready
//   is always high. Write only while no point is in flight.
// Path from input transfer to o_valid: the registered products, the clamped
//   sums, then one set-up, one stage per quotient bit and one rounding stage in
//   the three divider lanes, then the output register. Points that are not
//   divided take the same path length so order is kept.
// Throughput: one point per cycle while o_stall is low; the divider lanes are
//   fully pipelined.
// Stall: a stalled output holds its result; a single skid entry catches the
//   point leaving the pipeline, after which o_stall rises and the whole pipeline
//   holds until the output drains.
// Reset: synchronous, active low; clears all valid flags, loads the identity
//   matrix. Results in flight are dropped.
`include "homogeneous_transform_project_core_macros.svh"
module homogeneous_transform_project_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  hxp_pkg::t_coord               i_in_x,
    input  hxp_pkg::t_coord               i_in_y,
    input  hxp_pkg::t_coord               i_in_z,
    input  hxp_pkg::t_coord               i_in_w,
    output logic                          o_valid,
    input  logic                          i_stall,
    output hxp_pkg::t_coord               o_out_x,
    output hxp_pkg::t_coord               o_out_y,
    output hxp_pkg::t_coord               o_out_z,
    output hxp_pkg::t_coord               o_out_w,
    output logic                          o_divided,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hxp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hxp_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int LAT = hxp_pkg::DIV_LAT;

    logic [hxp_pkg::CFG_W-1:0] r_col [4];
    logic                      en;
    logic                      accept;
    logic                      r_s1_valid;
    logic                      r_s1_cmd;
    logic                      r_s2_valid;
    logic                      r_s2_cmd;
    hxp_pkg::t_coord           pin [4];
    hxp_pkg::t_coord           t   [4];
    logic [3:0]                tsat;
    hxp_pkg::t_ctl             r_ctl [LAT];
    hxp_pkg::t_ctl             n_ctl;
    hxp_pkg::t_coord           q   [3];
    logic [2:0]                qsat;
    hxp_pkg::t_res             pipe_res;
    hxp_pkg::t_res             r_out;
    logic                      r_out_valid;
    hxp_pkg::t_res             r_skid;
    logic                      r_skid_valid;

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= hxp_pkg::CFG_W'(1) << hxp_pkg::CFRAC;
            r_col[1] <= hxp_pkg::CFG_W'(1) << (hxp_pkg::CFRAC + hxp_pkg::LANE_W);
            r_col[2] <= hxp_pkg::CFG_W'(1) << (hxp_pkg::CFRAC + 2 * hxp_pkg::LANE_W);
            r_col[3] <= hxp_pkg::CFG_W'(1) << (hxp_pkg::CFRAC + 3 * hxp_pkg::LANE_W);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (hxp_pkg::t_cfg_reg'(i_cfg_index))
                hxp_pkg::CFG_COL0: r_col[0] <= i_cfg_data;
                hxp_pkg::CFG_COL1: r_col[1] <= i_cfg_data;
                hxp_pkg::CFG_COL2: r_col[2] <= i_cfg_data;
                hxp_pkg::CFG_COL3: r_col[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the skid entry is occupied
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !o_stall;

    assign pin[0] = i_in_x;
    assign pin[1] = i_in_y;
    assign pin[2] = i_in_z;
    assign pin[3] = i_in_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd <= i_cmd;
            r_s2_cmd <= r_s1_cmd;
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_col
        hxp_dot_lane u_dot (
            .i_clk (i_clk),
            .i_en  (en),
            .i_p   (pin),
            .i_col (r_col[c]),
            .o_t   (t[c]),
            .o_sat (tsat[c])
        );
    end

    for (genvar c = 0; c < 3; c++) begin : g_div
        hxp_div_lane u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_n   (t[c]),
            .i_w   (t[3]),
            .o_q   (q[c]),
            .o_sat (qsat[c])
        );
    end

    always_comb begin
        n_ctl.valid = r_s2_valid;
        n_ctl.div   = r_s2_cmd && (t[3] != '0) && (t[3] != hxp_pkg::ONE_COORD);
        n_ctl.sat   = |tsat;
        n_ctl.tx    = t[0];
        n_ctl.ty    = t[1];
        n_ctl.tz    = t[2];
        n_ctl.tw    = t[3];
    end

    // Hold the transformed values beside the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_ctl[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_ctl[0] <= n_ctl;
            for (int k = 1; k < LAT; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // Merge lanes
    always_comb begin
        pipe_res.w   = r_ctl[LAT-1].tw;
        pipe_res.div = r_ctl[LAT-1].div;
        if (r_ctl[LAT-1].div) begin
            pipe_res.x   = q[0];
            pipe_res.y   = q[1];
            pipe_res.z   = q[2];
            pipe_res.sat = r_ctl[LAT-1].sat || (|qsat);
        end else begin
            pipe_res.x   = r_ctl[LAT-1].tx;
            pipe_res.y   = r_ctl[LAT-1].ty;
            pipe_res.z   = r_ctl[LAT-1].tz;
            pipe_res.sat = r_ctl[LAT-1].sat;
        end
    end

    // Output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= r_ctl[LAT-1].valid;
                end
            end else if (en && r_ctl[LAT-1].valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : pipe_res;
        end else if (en && r_ctl[LAT-1].valid) begin
            r_skid <= pipe_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_x     = r_out.x;
    assign o_out_y     = r_out.y;
    assign o_out_z     = r_out.z;
    assign o_out_w     = r_out.w;
    assign o_divided   = r_out.div;
    assign o_saturated = r_out.sat;

    `HXP_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full with empty output")
    `HXP_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && i_stall, r_skid_valid, "skid lost while stalled")
    `HXP_ASSERT_NOW(a_div_w, i_clk, i_rst_n, o_valid && o_divided, (o_out_w != '0) && (o_out_w != hxp_pkg::ONE_COORD), "divide with w of zero or one")
    `HXP_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, r_out_valid && i_stall && !r_skid_valid && r_ctl[LAT-1].valid, r_skid_valid, "result leaving pipeline not caught")

endmodule

@@ src/hxp_dot_lane.sv @@
// One column of the 4x4 transform: four products, rounded sum, clamp.
// Depends on hxp_pkg.
module hxp_dot_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  hxp_pkg::t_coord            i_p [4],
    input  logic [hxp_pkg::CFG_W-1:0]  i_col,
    output hxp_pkg::t_coord            o_t,
    output logic                       o_sat
);

    logic signed [hxp_pkg::PROD_W-1:0] r_prod [4];
    logic signed [hxp_pkg::PROD_W-1:0] n_prod [4];
    logic signed [hxp_pkg::SUM_W-1:0]  sum;
    logic signed [hxp_pkg::SUM_W-1:0]  shf;
    logic signed [hxp_pkg::SUM_W-1:0]  cmax;
    logic signed [hxp_pkg::SUM_W-1:0]  cmin;
    hxp_pkg::t_coord                   r_t;
    logic                              r_sat;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_prod[r] = $signed(i_p[r])
                      * $signed(i_col[r*hxp_pkg::LANE_W +: hxp_pkg::COEF_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    // Round half up: add half an LSB, then floor.
    assign sum = hxp_pkg::SUM_W'(r_prod[0]) + hxp_pkg::SUM_W'(r_prod[1])
               + hxp_pkg::SUM_W'(r_prod[2]) + hxp_pkg::SUM_W'(r_prod[3])
               + (hxp_pkg::SUM_W'(1) <<< (hxp_pkg::CFRAC - 1));
    assign shf  = sum >>> hxp_pkg::CFRAC;
    assign cmax = hxp_pkg::SUM_W'({1'b0, {(hxp_pkg::COORD_BITS-1){1'b1}}});
    assign cmin = ~cmax;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (shf > cmax) begin
                r_t   <= cmax[hxp_pkg::COORD_BITS-1:0];
                r_sat <= 1'b1;
            end else if (shf < cmin) begin
                r_t   <= cmin[hxp_pkg::COORD_BITS-1:0];
                r_sat <= 1'b1;
            end else begin
                r_t   <= shf[hxp_pkg::COORD_BITS-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    assign o_t   = r_t;
    assign o_sat = r_sat;

endmodule

@@ src/hxp_div_lane.sv @@
// Pipelined restoring divider: (n << XFRAC) / w, one quotient bit per stage,
// rounded half away from zero and clamped. Depends on hxp_pkg.
module hxp_div_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  hxp_pkg::t_coord i_n,
    input  hxp_pkg::t_coord i_w,
    output hxp_pkg::t_coord o_q,
    output logic            o_sat
);

    localparam int CB = hxp_pkg::COORD_BITS;
    localparam int QW = hxp_pkg::QUO_W;

    // Index 0 is the set-up stage, index k+1 the stage that finds quotient bit QW-1-k.
    logic [CB-1:0] r_nm  [QW+1];
    logic [CB-1:0] r_d   [QW+1];
    logic [CB-1:0] r_rem [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_neg [QW+1];
    logic          r_nz  [QW+1];

    hxp_pkg::t_coord r_res;
    logic            r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nm[0]  <= i_n[CB-1] ? (~i_n + 1'b1) : i_n;
            r_d[0]   <= i_w[CB-1] ? (~i_w + 1'b1) : i_w;
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_neg[0] <= i_n[CB-1] ^ i_w[CB-1];
            r_nz[0]  <= (i_n != '0);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        logic        dbit;
        logic [CB:0] trial;
        logic        ge;

        if (QW - 1 - k >= hxp_pkg::XFRAC) begin : g_num
            assign dbit = r_nm[k][QW - 1 - k - hxp_pkg::XFRAC];
        end else begin : g_zero
            assign dbit = 1'b0;
        end

        assign trial = {r_rem[k], dbit};
        assign ge    = (trial >= {1'b0, r_d[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? CB'(trial - {1'b0, r_d[k]}) : trial[CB-1:0];
                r_q[k+1]   <= {r_q[k][QW-2:0], ge};
                r_nm[k+1]  <= r_nm[k];
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                r_nz[k+1]  <= r_nz[k];
            end
        end
    end

    logic          rnd;
    logic [QW:0]   q1;
    logic [QW:0]   qneg;
    logic [QW:0]   pos_max;
    logic [QW:0]   neg_max;

    assign rnd     = (r_rem[QW] >= (r_d[QW] - r_rem[QW]));
    assign q1      = {1'b0, r_q[QW]} + (QW+1)'(rnd);
    assign qneg    = (QW+1)'(0) - q1;
    assign pos_max = (QW+1)'({(CB-1){1'b1}});
    assign neg_max = (QW+1)'(1) << (CB - 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_nz[QW] || q1 == '0) begin
                r_res <= '0;
                r_sat <= 1'b0;
            end else if (r_neg[QW]) begin
                if (q1 > neg_max) begin
                    r_res <= {1'b1, {(CB-1){1'b0}}};
                    r_sat <= 1'b1;
                end else begin
                    r_res <= qneg[CB-1:0];
                    r_sat <= 1'b0;
                end
            end else begin
                if (q1 > pos_max) begin
                    r_res <= {1'b0, {(CB-1){1'b1}}};
                    r_sat <= 1'b1;
                end else begin
                    r_res <= q1[CB-1:0];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_q   = r_res;
    assign o_sat = r_sat;

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for homogeneous_transform_project_core: random matrices and points
// with random idling on both channels, checked against an in-bench fixed-point predictor.
// Depends on hxp_pkg and the core RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT   = 600000;
    localparam int DRAIN   = hxp_pkg::DIV_LAT + 10;
    localparam int N_RAND  = 1150;

    class xform_board;
        logic [hxp_pkg::CFG_W-1:0] col [4];
        hxp_pkg::t_res pending [$];
        int     errors;
        int     checked;
        int     n_div;
        int     n_sat;

        function new();
            col[0] = 64'h0000_0000_0000_1000;
            col[1] = 64'h0000_0000_1000_0000;
            col[2] = 64'h0000_1000_0000_0000;
            col[3] = 64'h1000_0000_0000_0000;
        endfunction

        function longint clamp(longint v, inout bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // (n << XFRAC) / w, magnitude rounded half away from zero
        function longint quot(longint n, longint w, inout bit sat);
            longint unsigned nm, d, q, r;
            bit neg;
            neg = (n < 0) != (w < 0);
            nm = (n < 0) ? -n : n;
            d  = (w < 0) ? -w : w;
            q  = (nm << hxp_pkg::XFRAC) / d;
            r  = (nm << hxp_pkg::XFRAC) % d;
            if (2 * r >= d) q++;
            if (n == 0 || q == 0) return 0;
            if (neg) begin
                if (q > 64'h8000_0000) begin
                    sat = 1;
                    return -64'sd2147483648;
                end
                return -longint'(q);
            end
            if (q > 64'h7FFF_FFFF) begin
                sat = 1;
                return 64'sd2147483647;
            end
            return longint'(q);
        endfunction

        function void note_point(logic c, hxp_pkg::t_coord x, hxp_pkg::t_coord y,
                                 hxp_pkg::t_coord z, hxp_pkg::t_coord w);
            longint p [4];
            longint t [4];
            longint acc;
            bit sat, dv;
            hxp_pkg::t_res e;
            p[0] = longint'(x); p[1] = longint'(y); p[2] = longint'(z); p[3] = longint'(w);
            sat = 0;
            dv  = 0;
            for (int k = 0; k < 4; k++) begin
                acc = 0;
                for (int r = 0; r < 4; r++)
                    acc += p[r] * longint'($signed(col[k][16*r +: 16]));
                t[k] = clamp((acc + (64'sd1 << (hxp_pkg::CFRAC - 1))) >>> hxp_pkg::CFRAC, sat);
            end
            if (c && t[3] != 0 && t[3] != (64'sd1 << hxp_pkg::XFRAC)) begin
                dv = 1;
                for (int k = 0; k < 3; k++) t[k] = quot(t[k], t[3], sat);
            end
            e.x = hxp_pkg::t_coord'(t[0]); e.y = hxp_pkg::t_coord'(t[1]);
            e.z = hxp_pkg::t_coord'(t[2]); e.w = hxp_pkg::t_coord'(t[3]);
            e.div = dv;
            e.sat = sat;
            n_div += dv;
            n_sat += sat;
            pending.push_back(e);
        endfunction

        function void check_result(hxp_pkg::t_res got);
            hxp_pkg::t_res e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with nothing expected: %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.w !== e.w ||
                got.div !== e.div || got.sat !== e.sat) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch at result %0d", checked);
                    $display("  expected x=%h y=%h z=%h w=%h div=%b sat=%b",
                             e.x, e.y, e.z, e.w, e.div, e.sat);
                    $display("  actual   x=%h y=%h z=%h w=%h div=%b sat=%b",
                             got.x, got.y, got.z, got.w, got.div, got.sat);
                end
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_cmd;
    hxp_pkg::t_coord               i_in_x, i_in_y, i_in_z, i_in_w;
    logic                          o_valid;
    logic                          i_stall;
    hxp_pkg::t_coord               o_out_x, o_out_y, o_out_z, o_out_w;
    logic                          o_divided;
    logic                          o_saturated;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [hxp_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [hxp_pkg::CFG_W-1:0]     i_cfg_data;

    xform_board board = new();
    int  cycles;
    bit  quiet;
    int  n_sent;
    int  n_mats;

    homogeneous_transform_project_core dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        hxp_pkg::t_res r;
        if (i_rst_n && o_valid && !i_stall) begin
            r.x = o_out_x; r.y = o_out_y; r.z = o_out_z; r.w = o_out_w;
            r.div = o_divided;
            r.sat = o_saturated;
            board.check_result(r);
        end
    end

    // Output back-pressure in bursts; none once the quiet tail starts
    initial begin
        forever begin
            if (quiet || $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    end

    task automatic send_point(logic c, hxp_pkg::t_coord x, hxp_pkg::t_coord y,
                              hxp_pkg::t_coord z, hxp_pkg::t_coord w);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= c;
        i_in_x  <= x;
        i_in_y  <= y;
        i_in_z  <= z;
        i_in_w  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_point(c, x, y, z, w);
        n_sent++;
    endtask

    // Drain everything in flight before touching the matrix
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_col(hxp_pkg::t_cfg_reg idx, logic [hxp_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.col[idx] = data;
    endtask

    task automatic load_matrix(logic [hxp_pkg::CFG_W-1:0] c0, logic [hxp_pkg::CFG_W-1:0] c1,
                               logic [hxp_pkg::CFG_W-1:0] c2, logic [hxp_pkg::CFG_W-1:0] c3);
        settle();
        write_col(hxp_pkg::CFG_COL0, c0);
        write_col(hxp_pkg::CFG_COL1, c1);
        write_col(hxp_pkg::CFG_COL2, c2);
        write_col(hxp_pkg::CFG_COL3, c3);
        i_cfg_valid <= 1'b0;
        n_mats++;
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 16'h4000)) - 32'sh2000);
        endcase
    endfunction

    function automatic logic [hxp_pkg::CFG_W-1:0] rand_col();
        return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function automatic hxp_pkg::t_coord rand_coord();
        case ($urandom_range(0, 11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0001_0000;
            3:       return 32'sh0000_0000;
            4, 5, 6: return hxp_pkg::t_coord'($urandom);
            default: return hxp_pkg::t_coord'($signed($urandom_range(0, 32'h0080_0000))
                                              - 32'sh40_0000);
        endcase
    endfunction

    task automatic random_points(int n);
        for (int i = 0; i < n; i++)
            send_point(1'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    initial begin
        quiet       = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= 1'b0;
        i_in_x      <= '0;
        i_in_y      <= '0;
        i_in_z      <= '0;
        i_in_w      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= hxp_pkg::CFG_COL0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity: extremes, w of exactly one and zero, both commands
        send_point(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0001_0000);
        send_point(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234, 32'sh0001_0000);
        send_point(1'b1, 32'sh0003_0000, 32'shFFFD_0000, 32'sh5, 32'sh0);
        send_point(1'b1, 32'sh0003_0000, 32'shFFFD_0000, 32'sh0001_8000, 32'sh0002_0000);
        send_point(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0000_0001);
        send_point(1'b1, 32'sh0000_0001, 32'sh0000_0003, 32'shFFFF_FFFF, 32'sh0004_0000);
        send_point(1'b1, 32'sh0100_0000, 32'shFF00_0000, 32'sh0, 32'shFFFF_0000);
        send_point(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh8000_0000);
        send_point(1'b0, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);

        // Full-scale entries force transform saturation and rounding edges
        load_matrix({4{16'h7FFF}}, {4{16'h8000}}, 64'h0, {16'h0800, 48'h0});
        send_point(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_point(1'b1, 32'sh0000_0001, 32'sh0, 32'sh0, 32'sh0002_0000);
        send_point(1'b1, 32'sh0000_0003, 32'shFFFF_FFFF, 32'sh0, 32'sh0003_0000);
        send_point(1'b1, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0);

        // Perspective: w' taken from z, so z of exactly one skips the divide
        load_matrix(64'h1000, 64'h1000_0000, 64'h1000_0000_0000, 64'h0000_1000_0000_0000);
        send_point(1'b1, 32'sh0005_0000, 32'shFFFB_0000, 32'sh0001_0000, 32'sh0);
        send_point(1'b1, 32'sh0005_0000, 32'shFFFB_0000, 32'sh0002_0000, 32'sh0);
        send_point(1'b1, 32'sh7FFF_0000, 32'sh8000_0000, 32'sh0000_0100, 32'sh0);
        send_point(1'b1, 32'sh0005_0000, 32'sh0, 32'shFFFE_0000, 32'sh0);

        random_points(N_RAND / 5);
        load_matrix(64'h0, 64'h0, 64'h0, 64'h0);
        random_points(20);
        for (int m = 0; m < 3; m++) begin
            load_matrix(rand_col(), rand_col(), rand_col(), rand_col());
            random_points(N_RAND / 5);
        end
        load_matrix(rand_col(), rand_col(), rand_col(), {rand_coef(), 48'h0});
        quiet = 1'b1;
        random_points(N_RAND / 5);

        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("%0d points through %0d matrices; %0d divided, %0d saturated",
                 n_sent, n_mats + 1, board.n_div, board.n_sat);
        $display("%0d results checked, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
